// ===== design/average_pooling_stream_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for average_pooling_stream
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef AVERAGE_POOLING_STREAM_TOP_DEFINES_SVH
`define AVERAGE_POOLING_STREAM_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/apool_pkg.sv =====
// ----------------------------------------------------------------------------
// apool_pkg
// Shared widths, register map, reset values and types of the pooling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apool_pkg;

    // Fixed field widths
    localparam int POS_W      = 8;   // row / column position and pooled index
    localparam int SIZE_W     = 9;   // map_width / map_height registers
    localparam int WIN_W      = 3;   // window_size register
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // Parameter defaults
    localparam int DEF_MAX_MAP_WIDTH = 256;
    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_MAX_WINDOW    = 4;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_MAP_WIDTH   = 9'd24;
    localparam logic [SIZE_W-1:0] RST_MAP_HEIGHT  = 9'd24;
    localparam logic [WIN_W-1:0]  RST_WINDOW_SIZE = 3'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCUM,
        ST_ABS,
        ST_DIV,
        ST_OUT
    } state_t;

    // Effective (clamped) geometry plus a write strobe
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [WIN_W-1:0]  win;
        logic              update;
    } geom_t;

endpackage

// ===== design/apool_ram.sv =====
// ----------------------------------------------------------------------------
// apool_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apool_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/apool_recip_div.sv =====
// ----------------------------------------------------------------------------
// apool_recip_div
// Unsigned divide by a small selectable constant (d or d*d, d = sel + 1),
// done as a multiply by a rounded-up reciprocal and a shift. Exact floor for
// every X_W-bit dividend. Registered quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apool_recip_div #(
    parameter int X_W     = 8,
    parameter int NUM_DIV = 4,
    parameter bit SQUARE  = 1'b0,
    localparam int SEL_W  = (NUM_DIV > 1) ? $clog2(NUM_DIV) : 1
) (
    input  logic             aclk,
    input  logic [X_W-1:0]   x,
    input  logic [SEL_W-1:0] sel,
    output logic [X_W-1:0]   q
);

    localparam int PROD_W = 2 * X_W + 1;

    logic [X_W-1:0] quo [NUM_DIV];
    logic [X_W-1:0] q_reg;

    // One constant multiplier per divisor
    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        localparam int D = SQUARE ? (g + 1) * (g + 1) : (g + 1);
        localparam int L = $clog2(D);
        localparam int S = X_W + L;
        localparam longint unsigned M_FULL =
            ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);
        localparam logic [X_W:0] M = M_FULL[X_W:0];

        logic [PROD_W-1:0] prod;

        assign prod   = PROD_W'(x) * PROD_W'(M);
        assign quo[g] = X_W'(prod >> S);
    end

    always_ff @(posedge aclk) begin
        q_reg <= quo[sel];
    end

    assign q = q_reg;

endmodule

// ===== design/apool_core.sv =====
// ----------------------------------------------------------------------------
// apool_core
// Position tracking, column-sum read-modify-write, mean and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "average_pooling_stream_top_defines.svh"

module apool_core #(
    parameter int MAX_MAP_WIDTH = apool_pkg::DEF_MAX_MAP_WIDTH,
    parameter int SAMPLE_BITS   = apool_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW    = apool_pkg::DEF_MAX_WINDOW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  apool_pkg::geom_t              geom,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average,
    output logic [apool_pkg::POS_W-1:0]   m_out_row,
    output logic [apool_pkg::POS_W-1:0]   m_out_col,
    output logic                          m_frame_done
);

    localparam int POS_W  = apool_pkg::POS_W;
    localparam int WIN_W  = apool_pkg::WIN_W;
    localparam int SIZE_W = apool_pkg::SIZE_W;
    localparam int AW     = $clog2(MAX_MAP_WIDTH);
    localparam int SUM_W  = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW);
    localparam int SEL_W  = $clog2(MAX_WINDOW);
    localparam int SPAN_W = POS_W + 1 + WIN_W;

    apool_pkg::state_t state_reg, state_next;

    logic [AW-1:0]    clr_cnt_reg;
    logic             hold_reg;
    logic [POS_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [POS_W-1:0] col_q, row_q;
    logic [SEL_W-1:0] div_sel;

    logic [SPAN_W-1:0] k_span, col_base, row_base;
    logic [SPAN_W-1:0] col_end1, row_end1, col_end2, row_end2;
    logic [WIN_W-1:0]  col_mod, row_mod, win_m1;
    logic              in_win, first_smp, last_smp, frame_end;
    logic              col_last, row_last, accept;

    logic [SAMPLE_BITS-1:0] item_sample_reg;
    logic [POS_W-1:0]       item_col_reg, item_row_reg;
    logic                   item_in_win_reg, item_first_reg, item_last_reg, item_done_reg;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [SUM_W-1:0] ram_wdata, ram_rdata;

    logic [SUM_W-1:0] sample_ext, sum_next, sum_reg, mag_next, mag_reg, avg_q, avg_fix;
    logic             neg_reg;

    logic                   out_load;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_average_reg;
    logic [POS_W-1:0]       m_row_reg, m_col_reg;
    logic                   m_done_reg;

    // Position divided by the window side, refreshed every cycle
    assign div_sel = SEL_W'(geom.win - WIN_W'(1));

    apool_recip_div #(
        .X_W     (POS_W),
        .NUM_DIV (MAX_WINDOW),
        .SQUARE  (1'b0)
    ) u_col_div (
        .aclk (aclk),
        .x    (col_reg),
        .sel  (div_sel),
        .q    (col_q)
    );

    apool_recip_div #(
        .X_W     (POS_W),
        .NUM_DIV (MAX_WINDOW),
        .SQUARE  (1'b0)
    ) u_row_div (
        .aclk (aclk),
        .x    (row_reg),
        .sel  (div_sel),
        .q    (row_q)
    );

    // Window magnitude divided by window area
    apool_recip_div #(
        .X_W     (SUM_W),
        .NUM_DIV (MAX_WINDOW),
        .SQUARE  (1'b1)
    ) u_avg_div (
        .aclk (aclk),
        .x    (mag_reg),
        .sel  (div_sel),
        .q    (avg_q)
    );

    // Column-sum line store
    apool_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_MAP_WIDTH)
    ) u_sums (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Window bookkeeping from position and quotient
    always_comb begin
        k_span    = SPAN_W'(geom.win);
        col_base  = SPAN_W'(col_q) * k_span;
        row_base  = SPAN_W'(row_q) * k_span;
        col_end1  = col_base + k_span;
        row_end1  = row_base + k_span;
        col_end2  = col_end1 + k_span;
        row_end2  = row_end1 + k_span;
        col_mod   = WIN_W'(SPAN_W'(col_reg) - col_base);
        row_mod   = WIN_W'(SPAN_W'(row_reg) - row_base);
        win_m1    = geom.win - WIN_W'(1);
        in_win    = (col_end1 <= SPAN_W'(geom.width)) && (row_end1 <= SPAN_W'(geom.height));
        first_smp = (col_mod == '0) && (row_mod == '0);
        last_smp  = (col_mod == win_m1) && (row_mod == win_m1);
        frame_end = (col_end2 > SPAN_W'(geom.width)) && (row_end2 > SPAN_W'(geom.height));
    end

    // Next scan position
    always_comb begin
        col_last = (SIZE_W'(col_reg) + SIZE_W'(1)) >= geom.width;
        row_last = (SIZE_W'(row_reg) + SIZE_W'(1)) >= geom.height;
        col_next = col_last ? '0 : col_reg + POS_W'(1);
        if (col_last) begin
            row_next = row_last ? '0 : row_reg + POS_W'(1);
        end else begin
            row_next = row_reg;
        end
    end

    assign s_ready = (state_reg == apool_pkg::ST_IDLE) && !hold_reg;
    assign accept  = s_valid && s_ready;

    // Sum update and magnitude
    always_comb begin
        sample_ext = {{(SUM_W - SAMPLE_BITS){item_sample_reg[SAMPLE_BITS-1]}}, item_sample_reg};
        sum_next   = item_first_reg ? sample_ext : ram_rdata + sample_ext;
        mag_next   = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
        avg_fix    = neg_reg ? (~avg_q + SUM_W'(1)) : avg_q;
    end

    // Line store ports: clear pass, read on accept, write back in ST_ACCUM
    always_comb begin
        ram_re    = accept;
        ram_raddr = AW'(col_q);
        if (state_reg == apool_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = (state_reg == apool_pkg::ST_ACCUM) && item_in_win_reg;
            ram_waddr = AW'(item_col_reg);
            ram_wdata = sum_next;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apool_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            apool_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == AW'(MAX_MAP_WIDTH - 1)) begin
                    state_next = apool_pkg::ST_IDLE;
                end
            end
            apool_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = apool_pkg::ST_ACCUM;
                end
            end
            apool_pkg::ST_ACCUM: begin
                if (item_in_win_reg && item_last_reg) begin
                    state_next = apool_pkg::ST_ABS;
                end else begin
                    state_next = apool_pkg::ST_IDLE;
                end
            end
            apool_pkg::ST_ABS: begin
                state_next = apool_pkg::ST_DIV;
            end
            apool_pkg::ST_DIV: begin
                state_next = apool_pkg::ST_OUT;
            end
            apool_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = apool_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = apool_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            hold_reg    <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // quotients are registered, so they trail a geometry write
            hold_reg <= geom.update;
            if (state_reg == apool_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_sample_reg <= s_sample;
            item_col_reg    <= col_q;
            item_row_reg    <= row_q;
            item_in_win_reg <= in_win;
            item_first_reg  <= first_smp;
            item_last_reg   <= last_smp;
            item_done_reg   <= frame_end;
        end
        if (state_reg == apool_pkg::ST_ACCUM) begin
            sum_reg <= sum_next;
        end
        if (state_reg == apool_pkg::ST_ABS) begin
            mag_reg <= mag_next;
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (out_load) begin
            m_average_reg <= avg_fix[SAMPLE_BITS-1:0];
            m_row_reg     <= item_row_reg;
            m_col_reg     <= item_col_reg;
            m_done_reg    <= item_done_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_average    = m_average_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_frame_done = m_done_reg;

    // Checks
    `APS_ASSERT_SAME(a_rw_apart, ram_re, !ram_we, "column-sum read and write collide")
    `APS_ASSERT_NEXT(a_accept_accum, accept, state_reg == apool_pkg::ST_ACCUM, "accepted word not accumulated")
    `APS_ASSERT_SAME(a_mod_range, accept, (col_mod < geom.win) && (row_mod < geom.win), "window offset out of range")
    `APS_ASSERT_SAME(a_write_after_read, (state_reg == apool_pkg::ST_ACCUM) && ram_we, $past(ram_re), "write-back without a read")

endmodule

// ===== design/average_pooling_stream_top.sv =====
// ----------------------------------------------------------------------------
// average_pooling_stream_top
// Streaming 2-D average pooling over non-overlapping square windows.
//
//   Channel  Dir  Handshake           Payload
//   s_       in   s_valid / s_ready   s_sample
//   m_       out  m_valid / m_ready   m_average, m_out_row, m_out_col, m_frame_done
//   APB      in   psel/penable/pready map_width, map_height, window_size
//
// The column-sum RAM is read on accept and the new sum written back the next
// cycle, in ST_ACCUM. A word that closes a window then passes through ST_ABS
// (magnitude), ST_DIV (reciprocal divide) and ST_OUT (result load), where it
// waits while the result register stays full. After reset a clearing pass
// zeroes all MAX_MAP_WIDTH line-store entries with s_ready low. s_ready also
// drops for one cycle after a register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module average_pooling_stream_top #(
    parameter int MAX_MAP_WIDTH = apool_pkg::DEF_MAX_MAP_WIDTH,
    parameter int SAMPLE_BITS   = apool_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW    = apool_pkg::DEF_MAX_WINDOW
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [apool_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [apool_pkg::APB_DATA_W-1:0] pwdata,
    output logic [apool_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    // input words
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample,
    // result words
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_average,
    output logic [apool_pkg::POS_W-1:0]      m_out_row,
    output logic [apool_pkg::POS_W-1:0]      m_out_col,
    output logic                             m_frame_done
);

    localparam int SIZE_W    = apool_pkg::SIZE_W;
    localparam int WIN_W     = apool_pkg::WIN_W;
    localparam int IDX_W     = apool_pkg::REG_IDX_W;
    localparam int DATA_W    = apool_pkg::APB_DATA_W;
    localparam int SIZE_CAP  = (MAX_MAP_WIDTH < 511) ? MAX_MAP_WIDTH : 511;
    localparam int WIN_CAP   = (MAX_WINDOW < 7) ? MAX_WINDOW : 7;

    logic [SIZE_W-1:0] map_width_reg, map_height_reg;
    logic [WIN_W-1:0]  window_size_reg;
    logic [IDX_W-1:0]  reg_idx;
    logic              cfg_wr;
    apool_pkg::geom_t  geom;

    assign pready  = 1'b1;
    assign reg_idx = paddr[IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg   <= apool_pkg::RST_MAP_WIDTH;
            map_height_reg  <= apool_pkg::RST_MAP_HEIGHT;
            window_size_reg <= apool_pkg::RST_WINDOW_SIZE;
        end else if (cfg_wr) begin
            case (reg_idx)
                apool_pkg::REG_MAP_WIDTH:   map_width_reg   <= pwdata[SIZE_W-1:0];
                apool_pkg::REG_MAP_HEIGHT:  map_height_reg  <= pwdata[SIZE_W-1:0];
                apool_pkg::REG_WINDOW_SIZE: window_size_reg <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            apool_pkg::REG_MAP_WIDTH:   prdata = DATA_W'(map_width_reg);
            apool_pkg::REG_MAP_HEIGHT:  prdata = DATA_W'(map_height_reg);
            apool_pkg::REG_WINDOW_SIZE: prdata = DATA_W'(window_size_reg);
            default:                    prdata = '0;
        endcase
    end

    // Clamp sizes: zero reads as one, large values saturate
    always_comb begin
        if (map_width_reg == '0) begin
            geom.width = SIZE_W'(1);
        end else if (map_width_reg > SIZE_W'(SIZE_CAP)) begin
            geom.width = SIZE_W'(SIZE_CAP);
        end else begin
            geom.width = map_width_reg;
        end
        if (map_height_reg == '0) begin
            geom.height = SIZE_W'(1);
        end else if (map_height_reg > SIZE_W'(SIZE_CAP)) begin
            geom.height = SIZE_W'(SIZE_CAP);
        end else begin
            geom.height = map_height_reg;
        end
        if (window_size_reg == '0) begin
            geom.win = WIN_W'(1);
        end else if (window_size_reg > WIN_W'(WIN_CAP)) begin
            geom.win = WIN_W'(WIN_CAP);
        end else begin
            geom.win = window_size_reg;
        end
        geom.update = cfg_wr;
    end

    apool_core #(
        .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .MAX_WINDOW    (MAX_WINDOW)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .geom         (geom),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_average    (m_average),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_done (m_frame_done)
    );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: average pooling stream testbench
// Streams feature-map words into average_pooling_stream_top under several map
// and window geometries set over APB. A scoreboard predicts each window mean
// and its row, column and frame_done flag, then checks the result words in
// order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int SMP_W     = apool_pkg::DEF_SAMPLE_BITS;
localparam int MAX_DIM   = apool_pkg::DEF_MAX_MAP_WIDTH;
localparam int MAX_WIN   = apool_pkg::DEF_MAX_WINDOW;

typedef logic signed [SMP_W-1:0] sample_t;

typedef struct {
    sample_t                     average;
    logic [apool_pkg::POS_W-1:0] row;
    logic [apool_pkg::POS_W-1:0] col;
    logic                        done;
} pooled_t;

// Window-mean predictor and in-order result checker
class window_mean_board;
    longint                       col_sums[MAX_DIM];
    int unsigned                  row_pos;
    int unsigned                  col_pos;
    logic [apool_pkg::SIZE_W-1:0] width_reg;
    logic [apool_pkg::SIZE_W-1:0] height_reg;
    logic [apool_pkg::WIN_W-1:0]  win_reg;
    pooled_t                      pending_means[$];
    int                           mismatches;

    function new();
        foreach (col_sums[n]) col_sums[n] = 0;
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = apool_pkg::RST_MAP_WIDTH;
        height_reg = apool_pkg::RST_MAP_HEIGHT;
        win_reg    = apool_pkg::RST_WINDOW_SIZE;
        mismatches = 0;
    endfunction

    // zero reads as 1, anything above the limit saturates
    function int unsigned dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function void write_reg(logic [apool_pkg::REG_IDX_W-1:0] idx,
                            logic [apool_pkg::APB_DATA_W-1:0] value);
        case (idx)
            apool_pkg::REG_MAP_WIDTH:   width_reg  = value[apool_pkg::SIZE_W-1:0];
            apool_pkg::REG_MAP_HEIGHT:  height_reg = value[apool_pkg::SIZE_W-1:0];
            apool_pkg::REG_WINDOW_SIZE: win_reg    = value[apool_pkg::WIN_W-1:0];
            default: ;
        endcase
    endfunction

    // words left until the position wraps back to the map origin
    function int unsigned words_to_frame_end();
        int unsigned w, h;
        w = dim(width_reg, MAX_DIM);
        h = dim(height_reg, MAX_DIM);
        if (row_pos < h && col_pos < w) return w * h - (row_pos * w + col_pos);
        return w * h;
    endfunction

    // accepted input word: update the line store, queue a mean on window close
    function void take_sample(sample_t s);
        int unsigned w, h, k, out_w, out_h, r, c, j, i;
        bit          opens_win, closes_win;
        pooled_t     mean;
        w     = dim(width_reg, MAX_DIM);
        h     = dim(height_reg, MAX_DIM);
        k     = dim(win_reg, MAX_WIN);
        out_w = w / k;
        out_h = h / k;
        r     = row_pos;
        c     = col_pos;
        if (c < out_w * k && r < out_h * k) begin
            j          = (c / k) % MAX_DIM;
            i          = r / k;
            opens_win  = (r % k == 0) && (c % k == 0);
            closes_win = (r % k == k - 1) && (c % k == k - 1);
            col_sums[j] = opens_win ? longint'(s) : col_sums[j] + longint'(s);
            if (closes_win) begin
                // signed division truncates toward zero
                mean.average = sample_t'(col_sums[j] / longint'(k * k));
                mean.row     = apool_pkg::POS_W'(i);
                mean.col     = apool_pkg::POS_W'(j);
                mean.done    = (i == out_h - 1) && (j == out_w - 1);
                pending_means.push_back(mean);
            end
        end
        // positions at or beyond the edge wrap on this word
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : ((r + 1) & 8'hFF);
        end else begin
            col_pos = (c + 1) & 8'hFF;
        end
    endfunction

    function void check_mean(sample_t avg, logic [apool_pkg::POS_W-1:0] row,
                             logic [apool_pkg::POS_W-1:0] col, logic done);
        pooled_t want;
        if (pending_means.size() == 0) begin
            $display("%0t: result word with none expected: avg %0d row %0d col %0d done %0b",
                     $time, avg, row, col, done);
            mismatches++;
            return;
        end
        want = pending_means.pop_front();
        if (avg !== want.average) begin
            $display("%0t: average expected %0d, got %0d", $time, want.average, avg);
            mismatches++;
        end
        if (row !== want.row) begin
            $display("%0t: out_row expected %0d, got %0d", $time, want.row, row);
            mismatches++;
        end
        if (col !== want.col) begin
            $display("%0t: out_col expected %0d, got %0d", $time, want.col, col);
            mismatches++;
        end
        if (done !== want.done) begin
            $display("%0t: frame_done expected %0b, got %0b", $time, want.done, done);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    localparam int RAND_WORDS = 580;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE_CYC = 12;

    logic                             aclk;
    logic                             aresetn;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [apool_pkg::APB_ADDR_W-1:0] paddr;
    logic [apool_pkg::APB_DATA_W-1:0] pwdata;
    logic [apool_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;
    logic                             s_valid;
    logic                             s_ready;
    sample_t                          s_sample;
    logic                             m_valid;
    logic                             m_ready;
    sample_t                          m_average;
    logic [apool_pkg::POS_W-1:0]      m_out_row;
    logic [apool_pkg::POS_W-1:0]      m_out_col;
    logic                             m_frame_done;

    window_mean_board means = new();
    bit               long_hold;
    int               send_quiet;
    int               sink_quiet;

    average_pooling_stream_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_average    (m_average),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_done (m_frame_done)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // mostly short gaps, a few long ones, and now and then a quiet stretch
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(40, 150);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return sample_t'(16'h7FFF);
            1:       return sample_t'(16'h8000);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // send one word; entered and left at a falling edge
    task automatic send_sample(input sample_t v);
        int gap;
        gap = pick_gap(send_quiet);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_sample = v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        means.take_sample(v);
        @(negedge aclk);
    endtask

    // drop valid, wait out every expected mean and any in-flight word
    task automatic settle();
        s_valid = 1'b0;
        while (means.pending_means.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    // APB write: setup then access; called at a falling edge with the block idle
    task automatic write_reg(input logic [apool_pkg::REG_IDX_W-1:0] idx,
                             input int unsigned value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        means.write_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned k);
        settle();
        write_reg(apool_pkg::REG_MAP_WIDTH, w);
        write_reg(apool_pkg::REG_MAP_HEIGHT, h);
        write_reg(apool_pkg::REG_WINDOW_SIZE, k);
    endtask

    // result side: random back-pressure, one long hold on request
    initial begin : result_sink
        int hold_n;
        hold_n     = 0;
        sink_quiet = 0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                hold_n    = LONG_HOLD;
            end
            if (hold_n > 0) begin
                m_ready = 1'b0;
                hold_n--;
            end else begin
                m_ready = 1'b1;
                hold_n  = pick_gap(sink_quiet);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            means.check_mean(m_average, m_out_row, m_out_col, m_frame_done);
    end

    // run limit
    initial begin
        #8_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int unsigned n_words, sent, phase, shape;
        send_quiet = 0;
        long_hold  = 1'b0;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_sample   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // 2x2 map, one window: full-scale positive, then a negative mean
        // that must round toward zero
        set_geometry(2, 2, 2);
        repeat (4) send_sample(sample_t'(16'h7FFF));
        repeat (3) send_sample(sample_t'(16'h8000));
        send_sample(sample_t'(16'h8001));

        // zero sizes and zero window all read as 1
        set_geometry(0, 0, 0);
        send_sample('0);
        send_sample(sample_t'(-1));

        // oversized window, clamped to 4, larger than a 3x2 map: no output
        set_geometry(3, 2, 7);
        repeat (3) send_sample(rand_sample());

        // resize in mid-frame; position and partial sums carry over
        set_geometry(4, 4, 2);
        repeat (3) send_sample(rand_sample());
        // shrink width under the current column: next word wraps and is dropped
        settle();
        write_reg(apool_pkg::REG_MAP_WIDTH, 2);
        repeat (3) send_sample(rand_sample());

        // random geometries; first two phases hit the widest and tallest maps
        sent  = 0;
        phase = 0;
        while (sent < RAND_WORDS) begin
            if (phase == 0) begin
                set_geometry($urandom_range(256, 511), 1, $urandom_range(0, 1));
                long_hold = 1'b1;
            end else if (phase == 1) begin
                set_geometry($urandom_range(0, 1), $urandom_range(256, 511), 1);
            end else begin
                shape = $urandom_range(0, 19);
                if (shape == 0)
                    set_geometry($urandom_range(256, 511), $urandom_range(0, 2),
                                 $urandom_range(0, 2));
                else if (shape == 1)
                    set_geometry($urandom_range(0, 2), $urandom_range(256, 511),
                                 $urandom_range(0, 2));
                else if (shape == 2)
                    settle();   // pause with the geometry unchanged
                else
                    set_geometry($urandom_range(0, 12), $urandom_range(0, 12),
                                 $urandom_range(0, 7));
            end
            // mostly finish the frame, sometimes stop part way through
            if (phase < 2 || $urandom_range(0, 3) != 0)
                n_words = means.words_to_frame_end();
            else
                n_words = $urandom_range(1, 30);
            // keep the total near the word budget
            if (phase >= 2 && n_words > RAND_WORDS - sent)
                n_words = RAND_WORDS - sent;
            repeat (n_words) send_sample(rand_sample());
            sent += n_words;
            phase++;
        end

        settle();
        repeat (20) @(negedge aclk);
        if (means.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
